@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character mapping of the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

	// character codes
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_PAD   = 8'd61;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_Z  = 8'd90;
	localparam logic [7:0] CH_LO_A  = 8'd97;
	localparam logic [7:0] CH_LO_Z  = 8'd122;

	// mapped values
	localparam logic [6:0] PAD_VALUE   = 7'd64;
	localparam logic [6:0] PLUS_VALUE  = 7'd62;
	localparam logic [6:0] SLASH_VALUE = 7'd63;
	localparam logic [7:0] DIGIT_ADD   = 8'd4;
	localparam logic [7:0] LOWER_SUB   = 8'd71;

	// group slot of the completing fourth character, which is not stored
	localparam logic [1:0] SLOT_LAST = 2'd3;

	// group queue sizing
	localparam int GQ_DEPTH = 4;
	localparam int GQ_AW    = $clog2(GQ_DEPTH);
	localparam int GQ_CW    = GQ_AW + 1;

	// input word
	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_buffer;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_run;
	} out_word_t;

	// one decoded group: up to three bytes and how many are valid
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [1:0] nbytes;
	} group_t;

	// group queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} gq_stat_t;

	// map one character to its 7-bit value, unknown codes give zero
	function automatic logic [6:0] char_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c == CH_PLUS) begin
				t = {1'b0, PLUS_VALUE};
			end else if (c == CH_SLASH) begin
				t = {1'b0, SLASH_VALUE};
			end else if (c == CH_PAD) begin
				t = {1'b0, PAD_VALUE};
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				t = c + DIGIT_ADD;
			end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
				t = c - CH_UP_A;
			end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
				t = c - LOWER_SUB;
			end
			return t[6:0];
		end
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them, collects groups of four and forms the bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire b64d_pkg::in_word_t  item,
	input  wire b64d_pkg::gq_stat_t  gq_stat,
	output logic                     gq_push,
	output b64d_pkg::group_t         gq_data
);
	import b64d_pkg::*;

	logic [6:0] store_q [3];
	logic [1:0] slot_q;
	logic [6:0] val;
	logic       accept;
	logic       group_done;
	logic [7:0] sum2;

	// only a completing character needs room in the group queue
	assign full       = (slot_q == SLOT_LAST) && gq_stat.full;
	assign accept     = push && !full;
	assign group_done = slot_q == SLOT_LAST;
	assign val        = char_value(item.char_in);

	// byte forming from the three stored values and the current one
	assign sum2 = {store_q[2][1:0], 6'd0} + {1'b0, val};

	always_comb begin
		gq_data.byte0 = {store_q[0][5:0], store_q[1][5:4]};
		gq_data.byte1 = {store_q[1][3:0], store_q[2][5:2]};
		gq_data.byte2 = sum2;
		if (store_q[2] == PAD_VALUE) begin
			gq_data.nbytes = 2'd1;
		end else if (val == PAD_VALUE) begin
			gq_data.nbytes = 2'd2;
		end else begin
			gq_data.nbytes = 2'd3;
		end
	end

	assign gq_push = accept && group_done;

	// slot counter, end of buffer drops a partial group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
		end else if (accept) begin
			if (item.end_of_buffer || group_done) begin
				slot_q <= 2'd0;
			end else begin
				slot_q <= slot_q + 2'd1;
			end
		end
	end

	// value store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q[0] <= 7'd0;
			store_q[1] <= 7'd0;
			store_q[2] <= 7'd0;
		end else if (accept && !group_done) begin
			store_q[slot_q] <= val;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/b64d_gq.sv @@
// ----------------------------------------------------------------------------
// b64d_gq
// Short queue of decoded groups between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_gq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire b64d_pkg::group_t   wdata,
	input  wire logic               pop,
	output b64d_pkg::group_t        rdata,
	output b64d_pkg::gq_stat_t      stat
);
	import b64d_pkg::*;

	group_t           mem_q [GQ_DEPTH];
	logic [GQ_AW-1:0] wr_q;
	logic [GQ_AW-1:0] rd_q;
	logic [GQ_CW-1:0] count_q;

	assign stat.full  = count_q == GQ_CW'(GQ_DEPTH);
	assign stat.empty = count_q == '0;
	assign rdata      = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("group queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("group queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("group queue count lost a word");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= GQ_CW'(GQ_DEPTH))
		else $error("group queue count out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Takes groups from the queue and hands out their bytes one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire b64d_pkg::group_t   gq_data,
	input  wire b64d_pkg::gq_stat_t gq_stat,
	output logic                    gq_pop,
	input  wire logic               pop,
	output logic                    empty,
	output b64d_pkg::out_word_t     result
);
	import b64d_pkg::*;

	group_t     grp_q;
	logic       grp_valid_q;
	logic [1:0] idx_q;
	out_word_t  out_q;
	logic       out_valid_q;
	logic       out_load;
	logic       emit;
	logic       last_idx;
	logic [7:0] cur_byte;

	assign empty  = !out_valid_q;
	assign result = out_q;

	// output slot frees when empty or taken this cycle
	assign out_load = !out_valid_q || pop;
	assign emit     = grp_valid_q && out_load;
	assign last_idx = idx_q == (grp_q.nbytes - 2'd1);
	assign gq_pop   = !gq_stat.empty && (!grp_valid_q || (emit && last_idx));

	// byte select within the group
	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = grp_q.byte0;
			2'd1:    cur_byte = grp_q.byte1;
			2'd2:    cur_byte = grp_q.byte2;
			default: cur_byte = grp_q.byte0;
		endcase
	end

	// current group and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (gq_pop) begin
				grp_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (emit) begin
				if (last_idx) begin
					grp_valid_q <= 1'b0;
					idx_q       <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gq_pop) begin
			grp_q <= gq_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.data_byte   <= cur_byte;
			out_q.last_in_run <= last_idx;
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid_q |-> idx_q < grp_q.nbytes)
		else $error("byte index beyond group size");
	a_nbytes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid_q |-> grp_q.nbytes != 2'd0)
		else $error("group with no bytes");
	a_last_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_idx && !gq_pop) |=> !grp_valid_q)
		else $error("group kept after its last byte");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/base64_decoder_top.sv @@
// ----------------------------------------------------------------------------
// base64_decoder_top
// Streaming base64 decoder: one character in, decoded bytes out.
// ----------------------------------------------------------------------------
//  channel | handshake         | word
//  input   | push / full       | item   : char_in[8], end_of_buffer[1]
//  result  | pop / empty       | result : data_byte[8], last_in_run[1]
//
// one character is taken per cycle; the fourth of a group forms its bytes
// in the same cycle and writes them to a four-deep group queue.
// the back side moves one byte per cycle into the output register when that
// register is empty or popped; bytes pass the queue, then the group register.
// input stalls only when a completing character meets a full group queue.
// reset clears the slot count, value store, queue pointers and fill count, and the group and output valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_decoder_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire b64d_pkg::in_word_t  item,
	input  wire logic                pop,
	output logic                     empty,
	output b64d_pkg::out_word_t      result
);
	import b64d_pkg::*;

	gq_stat_t gq_stat;
	group_t   gq_wdata;
	group_t   gq_rdata;
	logic     gq_push;
	logic     gq_pop;

	// character intake and group forming
	b64d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.gq_stat (gq_stat),
		.gq_push (gq_push),
		.gq_data (gq_wdata)
	);

	// group queue
	b64d_gq u_gq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (gq_push),
		.wdata  (gq_wdata),
		.pop    (gq_pop),
		.rdata  (gq_rdata),
		.stat   (gq_stat)
	);

	// byte output
	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.gq_data (gq_rdata),
		.gq_stat (gq_stat),
		.gq_pop  (gq_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

`default_nettype wire
